// ===== rtl/tlg_pkg.sv =====
// Package: shared constants, op and state codes, register indexes and the life rule.
`default_nettype none
package tlg_pkg;
  localparam int unsigned MaxRowsDefault = 64;
  localparam int unsigned MaxColsDefault = 64;
  localparam int unsigned RegW = 7;
  localparam int unsigned RowW = 6;
  localparam int unsigned ColW = 6;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_SWAP    = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_READ    = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RD,
    ST_RDW,
    ST_SWEEP,
    ST_OUT
  } state_e;

  function automatic logic life_rule(input logic [3:0] n, input logic self);
    return (n == 4'd3) || ((n == 4'd2) && self);
  endfunction
endpackage
`default_nettype wire

// ===== rtl/toroidal_life_grid_engine.sv =====
// Top level: toroidal B3/S23 life engine with two grids and a window-cell chain.
//
// channel   dir  fields (low bit up)
// s_axis    in   tdata: op[1:0] row[7:2] col[13:8] cell_in[14]
// m_axis    out  tdata: cell_out[0]
// cfg       in   idx 0 rows_in_use, idx 1 cols_in_use
//
// Write and swap pass through ST_RD to ST_OUT, read adds ST_RDW. Advance:
// per cell, 9 grid reads through one RAM read port into a 3-cell chain.
// After reset a clearing pass over every grid address (2^RW * 2^CW)
// zeros both grids.
// Input is held off while a beat waits on m_axis.
`default_nettype none
module toroidal_life_grid_engine
  import tlg_pkg::*;
#(
  parameter int unsigned MaxRows = MaxRowsDefault,
  parameter int unsigned MaxCols = MaxColsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // op, row, col, cell_in
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [7:0]  m_axis_tdata,  // cell_out
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [RegW-1:0] cfg_wdata_i
);
  localparam int unsigned RW = $clog2(MaxRows);
  localparam int unsigned CW = $clog2(MaxCols);
  localparam int unsigned AW = RW + CW;
  localparam int unsigned Depth = 2 ** AW;

  logic [RegW-1:0] rows_q, cols_q;
  logic cur_b_q;
  state_e st_q, st_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [RW-1:0] r_q, r_d;
  logic [CW-1:0] c_q, c_d;
  logic [3:0] k_q, k_d;
  logic [1:0] op_q, op_d;
  logic [RowW-1:0] irow_q, irow_d;
  logic [ColW-1:0] icol_q, icol_d;
  logic val_q, val_d, out_q, out_d, cur_b_d;
  logic [2:0] acc_q, acc_d;
  logic [2:0] win0, win1, win2;
  logic shift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RegW'(64);
      cols_q <= RegW'(64);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_ROWS) rows_q <= cfg_wdata_i;
      else cols_q <= cfg_wdata_i;
    end
  end

  logic [10:0] nr, nc;
  always_comb begin
    nr = (rows_q == '0) ? 11'd1 : ({4'd0, rows_q} > 11'(MaxRows) ? 11'(MaxRows) : {4'd0, rows_q});
    nc = (cols_q == '0) ? 11'd1 : ({4'd0, cols_q} > 11'(MaxCols) ? 11'(MaxCols) : {4'd0, cols_q});
  end

  logic in_grid;
  assign in_grid = ({5'd0, irow_q} < nr) && ({5'd0, icol_q} < nc);

  // neighbor coordinates for window read k: dr = k%3, dc = k/3
  logic [1:0] dr, dc;
  always_comb begin
    case (k_q)
      4'd0: begin dr = 2'd0; dc = 2'd0; end
      4'd1: begin dr = 2'd1; dc = 2'd0; end
      4'd2: begin dr = 2'd2; dc = 2'd0; end
      4'd3: begin dr = 2'd0; dc = 2'd1; end
      4'd4: begin dr = 2'd1; dc = 2'd1; end
      4'd5: begin dr = 2'd2; dc = 2'd1; end
      4'd6: begin dr = 2'd0; dc = 2'd2; end
      4'd7: begin dr = 2'd1; dc = 2'd2; end
      default: begin dr = 2'd2; dc = 2'd2; end
    endcase
  end

  logic [10:0] rr_s, cc_s, rr_w, cc_w;
  always_comb begin
    rr_s = 11'(r_q) + 11'(dr);
    cc_s = 11'(c_q) + 11'(dc);
    rr_w = (rr_s == 11'd0) ? nr - 11'd1 : ((rr_s - 11'd1 >= nr) ? rr_s - 11'd1 - nr : rr_s - 11'd1);
    cc_w = (cc_s == 11'd0) ? nc - 11'd1 : ((cc_s - 11'd1 >= nc) ? cc_s - 11'd1 - nc : cc_s - 11'd1);
  end

  logic we_a, we_b, wd;
  logic [AW-1:0] waddr, raddr;
  logic rd_a, rd_b;

  tlg_ram #(.Width(1), .Depth(Depth)) u_ram_a (
    .clk_i(clk_i), .we_i(we_a), .waddr_i(waddr), .wdata_i(wd),
    .raddr_i(raddr), .rdata_o(rd_a));
  tlg_ram #(.Width(1), .Depth(Depth)) u_ram_b (
    .clk_i(clk_i), .we_i(we_b), .waddr_i(waddr), .wdata_i(wd),
    .raddr_i(raddr), .rdata_o(rd_b));

  logic rd_cur;
  assign rd_cur = cur_b_q ? rd_b : rd_a;

  // window chain: acc gathers a column of 3, then shifts into three cells
  tlg_cell u_c0 (.clk_i(clk_i), .shift_i(shift), .col_i(acc_d), .col_o(win2));
  tlg_cell u_c1 (.clk_i(clk_i), .shift_i(shift), .col_i(win2), .col_o(win1));
  tlg_cell u_c2 (.clk_i(clk_i), .shift_i(shift), .col_i(win1), .col_o(win0));

  logic [3:0] ncnt;
  always_comb begin
    ncnt = 4'(win0[0]) + 4'(win0[1]) + 4'(win0[2]) + 4'(win1[0]) + 4'(win1[2])
         + 4'(win2[0]) + 4'(win2[1]) + 4'(win2[2]);
  end

  always_comb begin
    st_d = st_q; clr_d = clr_q; r_d = r_q; c_d = c_q; k_d = k_q;
    op_d = op_q; irow_d = irow_q; icol_d = icol_q; val_d = val_q;
    out_d = out_q; cur_b_d = cur_b_q; acc_d = acc_q;
    we_a = 1'b0; we_b = 1'b0; wd = 1'b0; waddr = '0; shift = 1'b0;
    raddr = {rr_w[RW-1:0], cc_w[CW-1:0]};
    s_axis_tready = (st_q == ST_IDLE);
    m_axis_tvalid = (st_q == ST_OUT);
    case (st_q)
      ST_CLEAR: begin
        we_a = 1'b1; we_b = 1'b1; waddr = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(Depth - 1)) st_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_d = s_axis_tdata[1:0];
          irow_d = s_axis_tdata[7:2];
          icol_d = s_axis_tdata[13:8];
          val_d = s_axis_tdata[14];
          out_d = 1'b0;
          r_d = '0; c_d = '0; k_d = '0;
          st_d = ST_RD;
        end
      end
      ST_RD: begin
        case (op_q)
          OP_WRITE: begin
            waddr = {RW'(irow_q), CW'(icol_q)}; wd = val_q;
            if (in_grid) begin we_a = cur_b_q; we_b = !cur_b_q; end
            st_d = ST_OUT;
          end
          OP_SWAP: begin cur_b_d = !cur_b_q; st_d = ST_OUT; end
          OP_ADVANCE: begin k_d = 4'd1; st_d = ST_SWEEP; end
          default: begin
            raddr = {RW'(irow_q), CW'(icol_q)};
            st_d = ST_RDW;
          end
        endcase
      end
      ST_RDW: begin
        out_d = in_grid & rd_cur;
        st_d = ST_OUT;
      end
      ST_SWEEP: begin
        // k_q names the read issued now; data of read k-1 arrives
        acc_d = acc_q;
        case (k_q)
          4'd1, 4'd4, 4'd7: acc_d[0] = rd_cur;
          4'd2, 4'd5, 4'd8: acc_d[1] = rd_cur;
          default: acc_d[2] = rd_cur;
        endcase
        if (k_q == 4'd3 || k_q == 4'd6 || k_q == 4'd9) shift = 1'b1;
        if (k_q == 4'd10) begin
          waddr = {r_q, c_q};
          wd = life_rule(ncnt, win1[1]);
          we_a = cur_b_q; we_b = !cur_b_q;
          k_d = '0;
          if (11'(c_q) == nc - 11'd1) begin
            c_d = '0;
            if (11'(r_q) == nr - 11'd1) begin
              cur_b_d = !cur_b_q; st_d = ST_OUT;
            end else r_d = r_q + 1'b1;
          end else c_d = c_q + 1'b1;
        end else k_d = k_q + 4'd1;
      end
      ST_OUT: begin
        if (m_axis_tready) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLEAR; clr_q <= '0; cur_b_q <= 1'b0; k_q <= '0;
    end else begin
      st_q <= st_d; clr_q <= clr_d; cur_b_q <= cur_b_d; k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d; c_q <= c_d; op_q <= op_d; irow_q <= irow_d; icol_q <= icol_d;
    val_q <= val_d; out_q <= out_d; acc_q <= acc_d;
  end

  assign m_axis_tdata = {7'd0, out_q};
endmodule
`default_nettype wire

// ===== rtl/tlg_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module tlg_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/tlg_cell.sv =====
// One cell of the window chain: holds a 3x3 window column slot and passes it on.
`default_nettype none
module tlg_cell (
  input  wire logic       clk_i,
  input  wire logic       shift_i,
  input  wire logic [2:0] col_i,
  output logic      [2:0] col_o
);
  logic [2:0] col_q;
  always_ff @(posedge clk_i) begin
    if (shift_i) col_q <= col_i;
  end
  assign col_o = col_q;
endmodule
`default_nettype wire

// ===== test/tb_toroidal_life_grid_engine.sv =====
// Testbench: stream stimulus and a self-checking life grid predictor for the engine.
`default_nettype none
module tb_toroidal_life_grid_engine
  import tlg_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [RegW-1:0] cfg_wdata_i = '0;

  toroidal_life_grid_engine dut (.*);

  always #4 clk_i = ~clk_i;

  typedef struct packed {
    logic       cell_in;
    logic [5:0] col;
    logic [5:0] row;
    op_e        op;
  } cmd_t;

  typedef struct {
    cmd_t cmd;
    bit   known;
    logic want_bit;
  } row_t;

  logic grid_q [2][64][64];
  bit cur_b;
  int unsigned n_rows = 64, n_cols = 64;
  logic cell_q [$];
  int errors = 0;
  bit rx_on = 1'b1;

  function automatic int unsigned fit(int unsigned v);
    return (v == 0) ? 1 : (v > 64 ? 64 : v);
  endfunction

  function automatic logic life_cell(int r, int c, int nr, int nc);
    int cnt;
    cnt = 0;
    for (int dr = -1; dr <= 1; dr++)
      for (int dc = -1; dc <= 1; dc++)
        if (dr != 0 || dc != 0)
          cnt += grid_q[cur_b][(r + nr + dr) % nr][(c + nc + dc) % nc];
    return (cnt == 3) || (cnt == 2 && grid_q[cur_b][r][c]);
  endfunction

  function automatic logic predict_cell(cmd_t cmd);
    int nr, nc;
    bit in_grid;
    logic res;
    nr = fit(n_rows);
    nc = fit(n_cols);
    in_grid = (cmd.row < nr) && (cmd.col < nc);
    res = 1'b0;
    case (cmd.op)
      OP_WRITE: if (in_grid) grid_q[!cur_b][cmd.row][cmd.col] = cmd.cell_in;
      OP_SWAP: cur_b = !cur_b;
      OP_ADVANCE: begin
        for (int r = 0; r < nr; r++)
          for (int c = 0; c < nc; c++)
            grid_q[!cur_b][r][c] = life_cell(r, c, nr, nc);
        cur_b = !cur_b;
      end
      default: if (in_grid) res = grid_q[cur_b][cmd.row][cmd.col];
    endcase
    return res;
  endfunction

  task automatic report(string what, logic got, logic want);
    errors++;
    $display("mismatch %s: got %0b want %0b at %0t", what, got, want, $time);
  endtask

  // tvalid stays high after a beat unless a gap follows; drain drops it
  task automatic send(cmd_t cmd, bit known = 0, logic want = 0);
    logic p;
    int gap;
    gap = $urandom_range(0, 14);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    p = predict_cell(cmd);
    if (known && p !== want) report("table", p, want);
    cell_q.push_back(p);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (cell_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_reg(reg_e idx, int unsigned v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v[RegW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_ROWS) n_rows = v & 7'h7f;
    else n_cols = v & 7'h7f;
  endtask

  function automatic cmd_t mk(op_e op, int r, int c, bit v);
    cmd_t x;
    x.op = op;
    x.row = 6'(r);
    x.col = 6'(c);
    x.cell_in = v;
    return x;
  endfunction

  // receiver
  initial begin
    int gap;
    logic want;
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (cell_q.size() == 0) report("unexpected beat", m_axis_tdata[0], 1'bx);
        else begin
          want = cell_q.pop_front();
          if (m_axis_tdata[0] !== want) report("cell_out", m_axis_tdata[0], want);
        end
        if (m_axis_tdata[7:1] !== '0) report("pad bits", 1'b1, 1'b0);
        gap = rx_on ? $urandom_range(0, 14) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    #200ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    row_t tbl [$];
    int unsigned sz [6] = '{0, 1, 2, 3, 100, 127};
    for (int r = 0; r < 64; r++)
      for (int c = 0; c < 64; c++) begin
        grid_q[0][r][c] = 0;
        grid_q[1][r][c] = 0;
      end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: small grid first, glider-free blinker on 5x5
    set_reg(REG_ROWS, 5);
    set_reg(REG_COLS, 5);
    tbl = '{
      '{mk(OP_READ, 0, 0, 0), 1, 0},
      '{mk(OP_READ, 63, 63, 0), 1, 0},
      '{mk(OP_WRITE, 2, 1, 1), 1, 0},
      '{mk(OP_WRITE, 2, 2, 1), 1, 0},
      '{mk(OP_WRITE, 2, 3, 1), 1, 0},
      '{mk(OP_WRITE, 63, 63, 1), 1, 0},
      '{mk(OP_SWAP, 0, 0, 0), 1, 0},
      '{mk(OP_READ, 2, 2, 0), 1, 1},
      '{mk(OP_READ, 63, 63, 0), 1, 0},
      '{mk(OP_ADVANCE, 0, 0, 0), 1, 0},
      '{mk(OP_READ, 1, 2, 0), 1, 1},
      '{mk(OP_READ, 2, 1, 0), 1, 0},
      '{mk(OP_ADVANCE, 0, 0, 0), 0, 0},
      '{mk(OP_READ, 2, 3, 0), 0, 0},
      '{mk(OP_WRITE, 0, 4, 1), 0, 0},
      '{mk(OP_WRITE, 4, 0, 1), 0, 0},
      '{mk(OP_ADVANCE, 0, 0, 0), 0, 0},
      '{mk(OP_READ, 0, 0, 0), 0, 0},
      '{mk(OP_READ, 4, 4, 0), 0, 0}
    };
    foreach (tbl[i]) send(tbl[i].cmd, tbl[i].known, tbl[i].want_bit);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 6) begin
        set_reg(REG_ROWS, 64);
        set_reg(REG_COLS, 64);
      end else begin
        set_reg(REG_ROWS, sz[$urandom_range(0, 5)]);
        set_reg(REG_COLS, sz[ph]);
      end
      rx_on = (ph % 3) != 2;
      for (int i = 0; i < (ph == 6 ? 12 : 20); i++) begin
        int k;
        op_e op;
        k = $urandom_range(0, 99);
        op = k < 45 ? OP_WRITE : k < 55 ? OP_SWAP : k < (ph == 6 ? 58 : 65) ? OP_ADVANCE
             : OP_READ;
        if (ph == 6 && op == OP_ADVANCE) op = OP_READ;
        send(mk(op, $urandom_range(0, 7) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 4),
                $urandom_range(0, 7) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 4),
                $urandom_range(0, 1)));
      end
      if (ph == 6) send(mk(OP_ADVANCE, 0, 0, 0));
      drain();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
